FILE: src/cilp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cilp_pkg
// Shared widths, character codes and the character class record of the
// C integer literal parser.
// ----------------------------------------------------------------------------
package cilp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CHAR_WIDTH  = 8;
  localparam int DIGIT_WIDTH = 4;

  localparam logic [CHAR_WIDTH-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ONE     = 8'h31;
  localparam logic [CHAR_WIDTH-1:0] CHAR_SEVEN   = 8'h37;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_F = 8'h46;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_L = 8'h4c;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_X = 8'h58;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_F = 8'h66;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_L = 8'h6c;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'h78;

  localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN = 4'ha;

  typedef struct packed {
    logic                   is_nul;
    logic                   is_zero;
    logic                   is_lead;
    logic                   is_oct;
    logic                   is_dec;
    logic                   is_hex;
    logic                   is_suffix;
    logic                   is_x;
    logic [DIGIT_WIDTH-1:0] digit;
  } char_class_t;

endpackage
`default_nettype wire

FILE: src/cilp_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cilp_classify
// Decodes one character into its class flags and its digit value.
// ----------------------------------------------------------------------------
module cilp_classify
  import cilp_pkg::*;
(
  input  wire logic [CHAR_WIDTH-1:0] char_code,
  output char_class_t                cls
);

  logic [CHAR_WIDTH-1:0] off_num;
  logic [CHAR_WIDTH-1:0] off_lower;
  logic [CHAR_WIDTH-1:0] off_upper;
  logic                  num;
  logic                  lower;
  logic                  upper;

  assign off_num   = char_code - CHAR_ZERO;
  assign off_lower = char_code - CHAR_LOWER_A;
  assign off_upper = char_code - CHAR_UPPER_A;
  assign num       = char_code inside {[CHAR_ZERO:CHAR_NINE]};
  assign lower     = char_code inside {[CHAR_LOWER_A:CHAR_LOWER_F]};
  assign upper     = char_code inside {[CHAR_UPPER_A:CHAR_UPPER_F]};

  always_comb begin
    cls.is_nul    = (char_code == CHAR_NUL);
    cls.is_zero   = (char_code == CHAR_ZERO);
    cls.is_lead   = char_code inside {[CHAR_ONE:CHAR_NINE]};
    cls.is_oct    = char_code inside {[CHAR_ZERO:CHAR_SEVEN]};
    cls.is_dec    = num;
    cls.is_hex    = num || lower || upper;
    cls.is_suffix = (char_code == CHAR_LOWER_L) || (char_code == CHAR_UPPER_L);
    cls.is_x      = (char_code == CHAR_LOWER_X) || (char_code == CHAR_UPPER_X);
    if (lower) begin
      cls.digit = DIGIT_TEN + off_lower[DIGIT_WIDTH-1:0];
    end else if (upper) begin
      cls.digit = DIGIT_TEN + off_upper[DIGIT_WIDTH-1:0];
    end else begin
      cls.digit = off_num[DIGIT_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: src/c_integer_literal_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c_integer_literal_parser
// Parses a NUL-terminated C integer literal, one character per beat, and
// gives the value with error and overflow flags on the terminating NUL.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while in_stall is low, set by the combinational shift-add.
// A NUL beat is held in the input register, then its result is registered at the output.
// The input stalls only while a NUL waits behind a result not yet taken.
// Reset (rst, synchronous, active high) empties both registers and returns
// the parser to the start of a literal with a cleared accumulator.
// ----------------------------------------------------------------------------
module c_integer_literal_parser
  import cilp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [CHAR_WIDTH-1:0]  char_code,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [VALUE_WIDTH-1:0]      value,
  output logic                        bad_literal,
  output logic                        overflowed
);

  localparam int WIDE = VALUE_WIDTH + DIGIT_WIDTH;

  typedef enum logic [2:0] {
    MODE_START, MODE_ZERO, MODE_OCT, MODE_DEC, MODE_HEX, MODE_SUFFIX, MODE_ERROR
  } mode_t;

  mode_t                  mode;
  mode_t                  mode_next;
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] acc_next;
  logic                   ovf;
  logic                   ovf_next;
  logic                   q_valid;
  logic [CHAR_WIDTH-1:0]  q_char;

  char_class_t            cls;
  logic                   advance;
  logic                   do_acc;
  logic                   digit_ok;
  logic [WIDE-1:0]        acc_wide;
  logic [WIDE-1:0]        prod;
  logic [WIDE-1:0]        sum;
  logic                   bad;

  cilp_classify u_classify (
    .char_code (q_char),
    .cls       (cls)
  );

  assign advance  = q_valid && (!cls.is_nul || !out_valid || !out_stall);
  assign in_stall = q_valid && !advance;

  assign acc_wide = {{DIGIT_WIDTH{1'b0}}, acc};

  always_comb begin
    case (mode)
      MODE_HEX: begin
        prod     = acc_wide << 4;
        digit_ok = cls.is_hex;
      end
      MODE_DEC: begin
        prod     = (acc_wide << 3) + (acc_wide << 1);
        digit_ok = cls.is_dec;
      end
      default: begin
        prod     = acc_wide << 3;
        digit_ok = cls.is_oct;
      end
    endcase
    sum = prod + {{(WIDE-DIGIT_WIDTH){1'b0}}, cls.digit};
  end

  always_comb begin
    mode_next = mode;
    do_acc    = 1'b0;
    case (mode)
      MODE_START: begin
        if (cls.is_zero) begin
          mode_next = MODE_ZERO;
        end else if (cls.is_lead) begin
          mode_next = MODE_DEC;
        end else begin
          mode_next = MODE_ERROR;
        end
      end
      MODE_ZERO: begin
        if (cls.is_x) begin
          mode_next = MODE_HEX;
        end else if (cls.is_suffix) begin
          mode_next = MODE_SUFFIX;
        end else if (cls.is_oct) begin
          mode_next = MODE_OCT;
          do_acc    = 1'b1;
        end else begin
          mode_next = MODE_ERROR;
        end
      end
      MODE_OCT, MODE_DEC, MODE_HEX: begin
        if (digit_ok) begin
          do_acc = 1'b1;
        end else if (cls.is_suffix) begin
          mode_next = MODE_SUFFIX;
        end else begin
          mode_next = MODE_ERROR;
        end
      end
      default: begin
        mode_next = MODE_ERROR;
      end
    endcase
  end

  always_comb begin
    acc_next = acc;
    ovf_next = ovf;
    if (mode == MODE_START && cls.is_lead) begin
      acc_next = {{(VALUE_WIDTH-DIGIT_WIDTH){1'b0}}, cls.digit};
    end else if (do_acc) begin
      acc_next = sum[VALUE_WIDTH-1:0];
      ovf_next = ovf || (sum[WIDE-1:VALUE_WIDTH] != '0);
    end
  end

  assign bad = (mode == MODE_START) || (mode == MODE_ERROR);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      q_char <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_START;
      acc       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        if (cls.is_nul) begin
          mode <= MODE_START;
          acc  <= '0;
          ovf  <= 1'b0;
        end else begin
          mode <= mode_next;
          acc  <= acc_next;
          ovf  <= ovf_next;
        end
      end
      if (advance && cls.is_nul) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (advance && cls.is_nul) begin
      value       <= bad ? '0 : acc;
      bad_literal <= bad;
      overflowed  <= !bad && ovf;
    end
  end

  a_bad_clears_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_literal |-> value == '0 && !overflowed)
    else $error("bad literal result carries a value or overflow flag");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid && q_char == CHAR_NUL && out_valid && out_stall)
    else $error("input stalled without a pending NUL behind a held result");

  a_nul_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && cls.is_nul |=> mode == MODE_START && acc == '0 && !ovf && out_valid)
    else $error("NUL beat did not restart the parser and post a result");

  a_start_acc_zero: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_START || mode == MODE_ZERO |-> acc == '0 && !ovf)
    else $error("accumulator not clear before the first nonzero digit");

endmodule
`default_nettype wire

FILE: tb/sv/c_integer_literal_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c_integer_literal_parser_tb
// Drives NUL-terminated character strings into the literal parser and checks
// each value, error and overflow result against a behavioral parser kept in a
// small scoreboard. The stimulus starts with directed corner literals and then
// sends random literals, mostly well-formed ones, under three idling mixes.
// There is also one long output hold-off.
// ----------------------------------------------------------------------------
module c_integer_literal_parser_tb
  import cilp_pkg::*;
();

  typedef logic [CHAR_WIDTH-1:0] char_q_t[$];

  typedef enum logic [2:0] {
    AT_START, AFTER_ZERO, IN_OCT, IN_DEC, IN_HEX, AFTER_SUFFIX, IN_ERROR
  } lit_mode_t;

  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    logic                   bad;
    logic                   ovf;
  } literal_result_t;

  class literal_scoreboard;
    lit_mode_t              mode;
    logic [VALUE_WIDTH-1:0] acc;
    logic                   ovf_seen;
    literal_result_t        pending_results[$];
    int                     mismatches;

    function new();
      mode       = AT_START;
      acc        = '0;
      ovf_seen   = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function int digit_value(logic [CHAR_WIDTH-1:0] c, int radix);
      int d;
      d = -1;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        d = c - CHAR_ZERO;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
        d = c - CHAR_LOWER_A + 10;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
        d = c - CHAR_UPPER_A + 10;
      end
      if (d >= radix) begin
        d = -1;
      end
      return d;
    endfunction

    function void add_digit(int radix, int d);
      logic [2*VALUE_WIDTH-1:0] wide;
      wide = {{VALUE_WIDTH{1'b0}}, acc} * (2*VALUE_WIDTH)'(radix) + (2*VALUE_WIDTH)'(d);
      if (wide[2*VALUE_WIDTH-1:VALUE_WIDTH] != '0) begin
        ovf_seen = 1'b1;
      end
      acc = wide[VALUE_WIDTH-1:0];
    endfunction

    function void note_char(logic [CHAR_WIDTH-1:0] c);
      literal_result_t r;
      logic            is_suffix;
      int              radix;
      int              d;
      is_suffix = (c == CHAR_LOWER_L) || (c == CHAR_UPPER_L);
      if (c == CHAR_NUL) begin
        r.bad   = (mode == AT_START) || (mode == IN_ERROR);
        r.value = r.bad ? '0 : acc;
        r.ovf   = !r.bad && ovf_seen;
        pending_results.push_back(r);
        mode     = AT_START;
        acc      = '0;
        ovf_seen = 1'b0;
        return;
      end
      case (mode)
        AT_START: begin
          if (c == CHAR_ZERO) begin
            mode = AFTER_ZERO;
          end else if (c >= CHAR_ONE && c <= CHAR_NINE) begin
            acc  = VALUE_WIDTH'(c - CHAR_ZERO);
            mode = IN_DEC;
          end else begin
            mode = IN_ERROR;
          end
        end
        AFTER_ZERO: begin
          if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
            mode = IN_HEX;
          end else if (is_suffix) begin
            mode = AFTER_SUFFIX;
          end else begin
            d = digit_value(c, 8);
            if (d >= 0) begin
              add_digit(8, d);
              mode = IN_OCT;
            end else begin
              mode = IN_ERROR;
            end
          end
        end
        IN_OCT, IN_DEC, IN_HEX: begin
          radix = (mode == IN_HEX) ? 16 : (mode == IN_DEC) ? 10 : 8;
          d = digit_value(c, radix);
          if (d >= 0) begin
            add_digit(radix, d);
          end else if (is_suffix) begin
            mode = AFTER_SUFFIX;
          end else begin
            mode = IN_ERROR;
          end
        end
        default: begin
          mode = IN_ERROR;
        end
      endcase
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t ns: %s", $time, msg);
      end
    endfunction

    function void check_result(logic [VALUE_WIDTH-1:0] v, logic b, logic o);
      literal_result_t e;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result value=%h bad=%b ovf=%b", v, b, o));
        return;
      end
      e = pending_results.pop_front();
      if (v !== e.value || b !== e.bad || o !== e.ovf) begin
        note_failure($sformatf("expected value=%h bad=%b ovf=%b, got value=%h bad=%b ovf=%b",
                               e.value, e.bad, e.ovf, v, b, o));
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [CHAR_WIDTH-1:0]  char_code = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [VALUE_WIDTH-1:0] value;
  logic                   bad_literal;
  logic                   overflowed;

  literal_scoreboard board;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   chars_sent = 0;

  c_integer_literal_parser u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .bad_literal (bad_literal),
    .overflowed  (overflowed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 200;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_result(value, bad_literal, overflowed);
    end
  end

  task automatic send_char(input logic [CHAR_WIDTH-1:0] c);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (in_stall);
    board.note_char(c);
    chars_sent++;
  endtask

  task automatic wait_all_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (board.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic logic [CHAR_WIDTH-1:0] hex_char(int d);
    if (d < 10) begin
      return CHAR_WIDTH'(CHAR_ZERO + d);
    end
    return CHAR_WIDTH'(($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + d - 10);
  endfunction

  function automatic char_q_t make_literal();
    char_q_t s;
    int      n;
    int      shape;
    int      idx;
    n = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(6);
    shape = $urandom_range(99);
    if (shape < 8) begin
      repeat (n + 1) s.push_back(CHAR_WIDTH'($urandom_range(1, 255)));
    end else begin
      case ($urandom_range(3))
        0: begin
          s.push_back(CHAR_WIDTH'(CHAR_ONE + $urandom_range(8)));
          repeat (n) s.push_back(CHAR_WIDTH'(CHAR_ZERO + $urandom_range(9)));
        end
        1: begin
          s.push_back(CHAR_ZERO);
          repeat (n) s.push_back(CHAR_WIDTH'(CHAR_ZERO + $urandom_range(7)));
        end
        2: begin
          s.push_back(CHAR_ZERO);
          s.push_back($urandom_range(1) ? CHAR_UPPER_X : CHAR_LOWER_X);
          repeat (n) s.push_back(hex_char($urandom_range(15)));
        end
        default: begin
          repeat (n + 1) s.push_back(CHAR_ZERO);
        end
      endcase
      if ($urandom_range(3) == 0) begin
        s.push_back($urandom_range(1) ? CHAR_UPPER_L : CHAR_LOWER_L);
      end
      if (shape < 23) begin
        idx = $urandom_range(s.size());
        if (idx == s.size()) begin
          s.push_back(CHAR_WIDTH'($urandom_range(1, 255)));
        end else begin
          s[idx] = CHAR_WIDTH'($urandom_range(1, 255));
        end
      end
    end
    s.push_back(CHAR_NUL);
    return s;
  endfunction

  initial begin
    char_q_t directed;
    char_q_t lit;
    board = new();
    directed = {CHAR_NUL,
                8'hff, CHAR_NUL,
                CHAR_ZERO, CHAR_ZERO, CHAR_NUL,
                CHAR_ZERO, CHAR_LOWER_X, CHAR_NUL,
                CHAR_ZERO, CHAR_UPPER_X, CHAR_UPPER_L, CHAR_NUL,
                CHAR_ZERO, CHAR_NINE, CHAR_NUL,
                CHAR_SEVEN, CHAR_UPPER_L, CHAR_NUL,
                CHAR_ONE, CHAR_LOWER_L, CHAR_LOWER_X, CHAR_NUL,
                CHAR_ONE, 8'h7a, CHAR_NUL};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle = 28;
    recv_idle = 86;
    foreach (directed[i]) send_char(directed[i]);
    while (chars_sent < 270) begin
      lit = make_literal();
      foreach (lit[i]) send_char(lit[i]);
    end
    wait_all_results();

    send_idle = 86;
    recv_idle = 28;
    while (chars_sent < 540) begin
      lit = make_literal();
      foreach (lit[i]) send_char(lit[i]);
    end
    wait_all_results();

    send_idle = 0;
    recv_idle = 0;
    hold_req <= 1'b1;
    while (chars_sent < 810) begin
      lit = make_literal();
      foreach (lit[i]) send_char(lit[i]);
    end
    wait_all_results();
    repeat (10) @(posedge clk);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
